FILE: design/cbpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_pkg
// Shared types and constants of the color bar pattern generator.
// ----------------------------------------------------------------------------
package cbpg_pkg;

  localparam int NUM_BARS    = 8;
  localparam int BAR_W       = 3;
  localparam int ADDR_W      = 24;
  localparam int COLOR_W     = 32;
  localparam int CFG_DIM_W   = 13;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int PIB_W       = 10;
  localparam int EXTRA_W     = 3;
  localparam int MIN_WIDTH   = 8;

  // reset values of the configuration registers
  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_WIDTH  = 13'd1080;
  localparam logic [CFG_DIM_W-1:0]  RST_FRAME_HEIGHT = 13'd720;
  localparam logic [CFG_DIM_W-1:0]  RST_LINE_STRIDE  = 13'd1090;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_0_1   = 64'd8589934593;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_2_3   = 64'd17179869187;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_4_5   = 64'd25769803781;
  localparam logic [CFG_DATA_W-1:0] RST_COLORS_6_7   = 64'd34359738375;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_LINE_STRIDE  = 3'd2,
    REG_COLORS_0_1   = 3'd3,
    REG_COLORS_2_3   = 3'd4,
    REG_COLORS_4_5   = 3'd5,
    REG_COLORS_6_7   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] frame_width;
    logic [CFG_DIM_W-1:0] frame_height;
    logic [CFG_DIM_W-1:0] line_stride;
  } frame_cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pixel_address;
    logic [BAR_W-1:0]  bar_index;
    logic              write_valid;
    logic              end_of_line;
    logic              end_of_frame;
    logic              config_error;
  } scan_result_t;

endpackage

FILE: design/cbpg_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_scan
// Raster scan state: column, line, bar position and buffer address, advanced
// by one pixel per accepted request.
// ----------------------------------------------------------------------------
module cbpg_scan #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_LINES       = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic                   restart,
  input  cbpg_pkg::frame_cfg_t   cfg,
  output cbpg_pkg::scan_result_t result
);
  import cbpg_pkg::*;

  localparam int COL_W  = (MAX_LINE_PIXELS > 1) ? $clog2(MAX_LINE_PIXELS) : 1;
  localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int WP_W   = $clog2(MAX_LINE_PIXELS + 1);
  localparam int HP_W   = $clog2(MAX_LINES + 1);
  localparam int WEFF_W = (WP_W > CFG_DIM_W) ? WP_W : CFG_DIM_W;
  localparam int HEFF_W = (HP_W > CFG_DIM_W) ? HP_W : CFG_DIM_W;
  localparam int CMP_W  = (WEFF_W > PIB_W + 1) ? WEFF_W : PIB_W + 1;
  localparam logic [PIB_W-1:0] PIB_MAX = {PIB_W{1'b1}};

  logic [BAR_W-1:0]   bar_index,   bar_index_next;
  logic [PIB_W-1:0]   pixel_in_bar, pixel_in_bar_next;
  logic [EXTRA_W-1:0] extra_left,  extra_left_next;
  logic [LINE_W-1:0]  line_number, line_number_next;
  logic [ADDR_W-1:0]  line_base,   line_base_next;
  logic [COL_W-1:0]   column,      column_next;

  logic               cfg_err, origin;
  logic [BAR_W-1:0]   cur_bar;
  logic [PIB_W-1:0]   cur_pib;
  logic [EXTRA_W-1:0] cur_extra, extra_eff;
  logic [LINE_W-1:0]  cur_line;
  logic [ADDR_W-1:0]  cur_base;
  logic [COL_W-1:0]   cur_col;
  logic [WEFF_W-1:0]  width_ext, weff, col_inc, bw, bar_len;
  logic [HEFF_W-1:0]  height_ext, heff_clamp, heff, line_inc;
  logic [EXTRA_W-1:0] rem;
  logic               eol, eof, bar_done;

  assign cfg_err = (cfg.frame_width < CFG_DIM_W'(MIN_WIDTH)) ||
                   (cfg.line_stride < cfg.frame_width);
  assign origin  = restart || cfg_err;

  assign cur_bar   = origin ? '0 : bar_index;
  assign cur_pib   = origin ? '0 : pixel_in_bar;
  assign cur_extra = origin ? '0 : extra_left;
  assign cur_line  = origin ? '0 : line_number;
  assign cur_base  = origin ? '0 : line_base;
  assign cur_col   = origin ? '0 : column;

  // oversized dimensions clamp to the maximum, zero height is one line
  assign width_ext  = WEFF_W'(cfg.frame_width);
  assign weff       = (width_ext > WEFF_W'(MAX_LINE_PIXELS)) ? WEFF_W'(MAX_LINE_PIXELS)
                                                             : width_ext;
  assign height_ext = HEFF_W'(cfg.frame_height);
  assign heff_clamp = (height_ext > HEFF_W'(MAX_LINES)) ? HEFF_W'(MAX_LINES) : height_ext;
  assign heff       = (heff_clamp == '0) ? HEFF_W'(1) : heff_clamp;

  assign bw  = weff >> 3;
  assign rem = weff[EXTRA_W-1:0];

  assign extra_eff = (cur_col == '0) ? rem : cur_extra;
  assign col_inc   = WEFF_W'(cur_col) + WEFF_W'(1);
  assign line_inc  = HEFF_W'(cur_line) + HEFF_W'(1);
  assign eol       = col_inc >= weff;
  assign eof       = eol && (line_inc >= heff);
  assign bar_len   = bw + ((extra_eff != '0) ? WEFF_W'(1) : '0);
  assign bar_done  = (CMP_W'(cur_pib) + CMP_W'(1)) >= CMP_W'(bar_len);

  always_comb begin
    result.pixel_address = cfg_err ? '0 : cur_base + ADDR_W'(cur_col);
    result.bar_index     = cur_bar;
    result.write_valid   = !cfg_err;
    result.end_of_line   = !cfg_err && eol;
    result.end_of_frame  = !cfg_err && eof;
    result.config_error  = cfg_err;
  end

  always_comb begin
    bar_index_next    = cur_bar;
    pixel_in_bar_next = cur_pib;
    extra_left_next   = extra_eff;
    line_number_next  = cur_line;
    line_base_next    = cur_base;
    column_next       = cur_col;
    if (cfg_err) begin
      extra_left_next = '0;
    end else if (eol) begin
      column_next       = '0;
      bar_index_next    = '0;
      pixel_in_bar_next = '0;
      extra_left_next   = rem;
      if (eof) begin
        line_number_next = '0;
        line_base_next   = '0;
      end else begin
        line_number_next = line_inc[LINE_W-1:0];
        line_base_next   = cur_base + ADDR_W'(cfg.line_stride);
      end
    end else begin
      column_next = col_inc[COL_W-1:0];
      if (bar_done && (cur_bar < BAR_W'(NUM_BARS - 1))) begin
        bar_index_next    = cur_bar + BAR_W'(1);
        pixel_in_bar_next = '0;
        if (extra_eff != '0) begin
          extra_left_next = extra_eff - EXTRA_W'(1);
        end
      end else if (cur_pib < PIB_MAX) begin
        pixel_in_bar_next = cur_pib + PIB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_index    <= '0;
      pixel_in_bar <= '0;
      extra_left   <= '0;
      line_number  <= '0;
      line_base    <= '0;
      column       <= '0;
    end else if (advance) begin
      bar_index    <= bar_index_next;
      pixel_in_bar <= pixel_in_bar_next;
      extra_left   <= extra_left_next;
      line_number  <= line_number_next;
      line_base    <= line_base_next;
      column       <= column_next;
    end
  end

endmodule

FILE: design/color_bar_pattern_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_bar_pattern_generator
// Eight vertical color bars written into a strided frame buffer, one pixel
// write per accepted request.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | req_valid, req_stall | restart
//  pixel    | pix_valid, pix_stall | pixel_address, pixel_color, write_valid,
//           |                      | end_of_line, end_of_frame, config_error
//  config   | cfg_write            | cfg_index, cfg_data
//
// One pixel per cycle while the output is not stalled; a request's result is in the output
// register in the cycle after it is accepted. The scan state update is a single pass of column and
// address adders, so a request is taken every cycle the output can move.
// req_stall is high only while a held pixel is stalled.
// Reset puts the scan at the frame origin and loads default registers.
module color_bar_pattern_generator #(
  parameter int MAX_LINE_PIXELS = 4096,
  parameter int MAX_LINES       = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             restart,
  output logic                             pix_valid,
  input  logic                             pix_stall,
  output logic [cbpg_pkg::ADDR_W-1:0]      pixel_address,
  output logic [cbpg_pkg::COLOR_W-1:0]     pixel_color,
  output logic                             write_valid,
  output logic                             end_of_line,
  output logic                             end_of_frame,
  output logic                             config_error,
  input  logic                             cfg_write,
  input  logic [cbpg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbpg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cbpg_pkg::*;

  frame_cfg_t            cfg;
  logic [CFG_DATA_W-1:0] colors [NUM_BARS/2];
  scan_result_t          res;
  logic                  accept;
  logic [CFG_DATA_W-1:0] color_pair;
  logic [COLOR_W-1:0]    color_sel;

  assign req_stall = pix_valid && pix_stall;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.line_stride  <= RST_LINE_STRIDE;
      colors[0]        <= RST_COLORS_0_1;
      colors[1]        <= RST_COLORS_2_3;
      colors[2]        <= RST_COLORS_4_5;
      colors[3]        <= RST_COLORS_6_7;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[CFG_DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data[CFG_DIM_W-1:0];
        REG_LINE_STRIDE:  cfg.line_stride  <= cfg_data[CFG_DIM_W-1:0];
        REG_COLORS_0_1:   colors[0]        <= cfg_data;
        REG_COLORS_2_3:   colors[1]        <= cfg_data;
        REG_COLORS_4_5:   colors[2]        <= cfg_data;
        REG_COLORS_6_7:   colors[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  cbpg_scan #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS),
    .MAX_LINES      (MAX_LINES)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .advance(accept),
    .restart(restart),
    .cfg    (cfg),
    .result (res)
  );

  // odd bars sit in the upper half of each pair
  assign color_pair = colors[res.bar_index[BAR_W-1:1]];
  assign color_sel  = res.config_error ? '0 :
                      res.bar_index[0] ? color_pair[CFG_DATA_W-1:COLOR_W]
                                       : color_pair[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (accept) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_address <= res.pixel_address;
      pixel_color   <= color_sel;
      write_valid   <= res.write_valid;
      end_of_line   <= res.end_of_line;
      end_of_frame  <= res.end_of_frame;
      config_error  <= res.config_error;
    end
  end

endmodule

FILE: design/cbpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbpg_checker
// Port-level checks of the color bar pattern generator, bound to the top.
// ----------------------------------------------------------------------------
module cbpg_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_stall,
  input logic                         pix_valid,
  input logic                         pix_stall,
  input logic [cbpg_pkg::ADDR_W-1:0]  pixel_address,
  input logic [cbpg_pkg::COLOR_W-1:0] pixel_color,
  input logic                         write_valid,
  input logic                         end_of_line,
  input logic                         end_of_frame,
  input logic                         config_error
);
  import cbpg_pkg::*;

  // a bad configuration yields an empty, non-write pixel
  assert property (@(posedge clk) disable iff (rst)
    pix_valid && config_error |-> !write_valid && !end_of_line && !end_of_frame &&
      pixel_address == '0 && pixel_color == '0)
    else $error("config error pixel carries a write");

  assert property (@(posedge clk) disable iff (rst)
    pix_valid && end_of_frame |-> end_of_line && write_valid)
    else $error("end of frame without end of line");

  // requests back up only behind a stalled pixel
  assert property (@(posedge clk) disable iff (rst)
    req_stall == (pix_valid && pix_stall))
    else $error("request stall not tied to output stall");

  assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_stall |=> pix_valid && $stable(pixel_address) && $stable(pixel_color))
    else $error("stalled pixel changed");

  assert property (@(posedge clk) rst |=> !pix_valid)
    else $error("pixel valid after reset");

endmodule

bind color_bar_pattern_generator cbpg_checker u_cbpg_checker (
  .clk          (clk),
  .rst          (rst),
  .req_stall    (req_stall),
  .pix_valid    (pix_valid),
  .pix_stall    (pix_stall),
  .pixel_address(pixel_address),
  .pixel_color  (pixel_color),
  .write_valid  (write_valid),
  .end_of_line  (end_of_line),
  .end_of_frame (end_of_frame),
  .config_error (config_error)
);
